@@ hw/rtl/cartridge_bank_address_mapper_unit_defines.svh @@
// Assertion macros shared by the cartridge bank address mapper RTL.
`ifndef CARTRIDGE_BANK_ADDRESS_MAPPER_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_ADDRESS_MAPPER_UNIT_DEFINES_SVH

// The expression holds at every rising clock edge outside reset.
`define CBAM_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("cbam: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define CBAM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbam: implication violated");

// The consequent holds in the cycle after the antecedent.
`define CBAM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbam: next-cycle implication violated");

`endif

@@ hw/rtl/cbam_pkg.sv @@
// Types and address map constants of the cartridge bank address mapper.
`timescale 1ns / 1ps
package cbam_pkg;

	typedef enum logic [1:0] {
		TGT_ROM  = 2'd0,
		TGT_RAM  = 2'd1,
		TGT_INT  = 2'd2,
		TGT_NONE = 2'd3
	} target_t;

	localparam int unsigned PHYS_W = 21;

	localparam logic [15:0] ADDR_BANK_REG  = 16'h2000;
	localparam logic [15:0] ADDR_ROM_BANKN = 16'h4000;
	localparam logic [15:0] ADDR_LATCH     = 16'h6000;
	localparam logic [15:0] ADDR_VRAM      = 16'h8000;
	localparam logic [15:0] ADDR_CART_RAM  = 16'hA000;
	localparam logic [15:0] ADDR_WRAM      = 16'hC000;
	localparam logic [15:0] ADDR_ECHO      = 16'hE000;
	localparam logic [15:0] ADDR_OAM       = 16'hFE00;
	localparam logic [15:0] ADDR_UNUSABLE  = 16'hFEA0;
	localparam logic [15:0] ADDR_IO_START  = 16'hFEFF;
	localparam logic [15:0] ECHO_OFFSET    = 16'h2000;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

endpackage

@@ hw/rtl/cartridge_bank_address_mapper_unit.sv @@
// Top level of the cartridge bank address mapper: bank registers and address decode.
`timescale 1ns / 1ps
// An accepted bus word passes through the input register and then the output register to its result word.
// Throughput: one word per cycle; the input register advances whenever the output register
// is empty or its word is being taken, and the bank registers update in that same cycle.
// Reset: arst_n clears both valid flags, disables cartridge RAM, selects ROM bank 1
// and RAM bank 0.
`include "cartridge_bank_address_mapper_unit_defines.svh"
module cartridge_bank_address_mapper_unit #(
	parameter int ROM_BANK_BITS = 7,
	parameter int RAM_BANKS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          action,
	input  logic [15:0]                   bus_address,
	input  logic [7:0]                    write_byte,
	output logic                          result_valid,
	input  logic                          result_stall,
	output cbam_pkg::target_t             target,
	output logic [cbam_pkg::PHYS_W-1:0]   physical_address,
	output logic                          store_strobe,
	output logic [7:0]                    store_byte
);
	import cbam_pkg::*;

	localparam int RamBankW = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
	localparam int RamRecip = (65536 + RAM_BANKS - 1) / RAM_BANKS;

	logic                valid_s1;
	logic                action_s1;
	logic [15:0]         address_s1;
	logic [7:0]          byte_s1;

	logic                ram_enabled_q;
	logic [ROM_BANK_BITS-1:0] rom_bank_q;
	logic [RamBankW-1:0] ram_bank_q;

	logic                advance;
	target_t             tgt_d;
	logic [PHYS_W-1:0]   phys_d;
	logic                strobe_d;

	logic [ROM_BANK_BITS-1:0] rom_bank_d;
	logic [21:0]         rom_phys;
	logic [24:0]         mod_prod;
	logic [7:0]          mod_quot;
	logic [11:0]         mod_rem;
	logic [11:0]         mod_fix;

	assign advance    = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1  <= action;
			address_s1 <= bus_address;
			byte_s1    <= write_byte;
		end
	end

	// The RAM bank is the written byte modulo RAM_BANKS, found through a reciprocal.
	assign mod_prod = {17'd0, byte_s1} * 25'(RamRecip);
	assign mod_quot = mod_prod[23:16];
	assign mod_rem  = {4'd0, byte_s1} - (12'(mod_quot) * 12'(RAM_BANKS));
	assign mod_fix  = (mod_rem >= 12'(RAM_BANKS)) ? (mod_rem - 12'(RAM_BANKS)) : mod_rem;

	assign rom_bank_d = (byte_s1[ROM_BANK_BITS-1:0] == '0) ? ROM_BANK_BITS'(1)
		: byte_s1[ROM_BANK_BITS-1:0];
	assign rom_phys = {8'(rom_bank_q), address_s1[13:0]};

	always_comb begin
		tgt_d    = TGT_NONE;
		phys_d   = '0;
		if (address_s1 < ADDR_VRAM) begin
			if (!action_s1) begin
				tgt_d = TGT_ROM;
				if (address_s1 < ADDR_ROM_BANKN) begin
					phys_d = PHYS_W'(address_s1);
				end else begin
					phys_d = rom_phys[PHYS_W-1:0];
				end
			end
		end else if (address_s1 < ADDR_CART_RAM
				|| (address_s1 >= ADDR_WRAM && address_s1 < ADDR_ECHO)) begin
			tgt_d  = TGT_INT;
			phys_d = PHYS_W'(address_s1);
		end else if (address_s1 < ADDR_WRAM) begin
			if (ram_enabled_q) begin
				tgt_d  = TGT_RAM;
				phys_d = PHYS_W'({ram_bank_q, address_s1[12:0]});
			end
		end else if (address_s1 < ADDR_OAM) begin
			tgt_d  = TGT_INT;
			phys_d = PHYS_W'(address_s1 - ECHO_OFFSET);
		end else if (address_s1 < ADDR_UNUSABLE || address_s1 >= ADDR_IO_START) begin
			tgt_d  = TGT_INT;
			phys_d = PHYS_W'(address_s1);
		end
		strobe_d = action_s1 && (tgt_d == TGT_INT || tgt_d == TGT_RAM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q <= 1'b0;
			rom_bank_q    <= ROM_BANK_BITS'(1);
			ram_bank_q    <= '0;
		end else if (valid_s1 && advance && action_s1 && address_s1 < ADDR_LATCH) begin
			if (address_s1 < ADDR_BANK_REG) begin
				ram_enabled_q <= (byte_s1[3:0] == RAM_ENABLE_KEY);
			end else if (address_s1 < ADDR_ROM_BANKN) begin
				rom_bank_q <= rom_bank_d;
			end else begin
				ram_bank_q <= mod_fix[RamBankW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			target           <= tgt_d;
			physical_address <= phys_d;
			store_strobe     <= strobe_d;
			store_byte       <= strobe_d ? byte_s1 : 8'd0;
		end
	end

	`CBAM_ASSERT_ALWAYS(a_rom_bank_nonzero, rom_bank_q != '0)
	`CBAM_ASSERT_ALWAYS(a_ram_bank_in_range, 32'(ram_bank_q) < 32'(RAM_BANKS))
	`CBAM_ASSERT_IMPL(a_strobe_target, result_valid && store_strobe, target == TGT_RAM || target == TGT_INT)
	`CBAM_ASSERT_IMPL(a_none_is_quiet, result_valid && target == TGT_NONE, physical_address == '0 && !store_strobe && store_byte == 8'd0)
	`CBAM_ASSERT_NEXT(a_ram_enable_write, valid_s1 && advance && action_s1 && address_s1 < ADDR_BANK_REG, ram_enabled_q == ($past(byte_s1[3:0]) == RAM_ENABLE_KEY))

endmodule

@@ bench/cartridge_bank_address_mapper_unit_tb.sv @@
// Self-checking testbench for the cartridge bank address mapper with a bank-state predictor.
`timescale 1ns / 1ps

typedef struct {
	cbam_pkg::target_t tgt;
	logic [20:0]       phys;
	logic              strobe;
	logic [7:0]        sbyte;
} bank_map_t;

class bank_map_ledger;
	int unsigned rom_bits;
	int unsigned ram_banks;
	bit          ram_on;
	int unsigned rom_bank;
	int unsigned ram_bank;
	bank_map_t   awaited_maps[$];
	int unsigned failures;

	function new(int unsigned rom_bits_i, int unsigned ram_banks_i);
		rom_bits = rom_bits_i;
		ram_banks = ram_banks_i;
		ram_on = 1'b0;
		rom_bank = 1;
		ram_bank = 0;
		failures = 0;
	endfunction

	function int unsigned awaited();
		return awaited_maps.size();
	endfunction

	function void note_access(logic wr, logic [15:0] addr, logic [7:0] data);
		bank_map_t   m;
		logic [31:0] lin;
		int unsigned sel;
		m.tgt = cbam_pkg::TGT_NONE;
		lin = 32'd0;
		if (addr < cbam_pkg::ADDR_VRAM) begin
			if (!wr) begin
				m.tgt = cbam_pkg::TGT_ROM;
				if (addr < cbam_pkg::ADDR_ROM_BANKN)
					lin = {16'd0, addr};
				else
					lin = rom_bank * 32'h4000 + {16'd0, addr} - {16'd0, cbam_pkg::ADDR_ROM_BANKN};
			end else if (addr < cbam_pkg::ADDR_BANK_REG) begin
				ram_on = (data[3:0] == cbam_pkg::RAM_ENABLE_KEY);
			end else if (addr < cbam_pkg::ADDR_ROM_BANKN) begin
				sel = data & (((1 << rom_bits) - 1) & 8'hFF);
				rom_bank = (sel == 0) ? 1 : sel;
			end else if (addr < cbam_pkg::ADDR_LATCH) begin
				ram_bank = data % ram_banks;
			end
		end else if (addr < cbam_pkg::ADDR_CART_RAM ||
				(addr >= cbam_pkg::ADDR_WRAM && addr < cbam_pkg::ADDR_ECHO)) begin
			m.tgt = cbam_pkg::TGT_INT;
			lin = {16'd0, addr};
		end else if (addr < cbam_pkg::ADDR_WRAM) begin
			if (ram_on) begin
				m.tgt = cbam_pkg::TGT_RAM;
				lin = ram_bank * 32'h2000 + {16'd0, addr} - {16'd0, cbam_pkg::ADDR_CART_RAM};
			end
		end else if (addr < cbam_pkg::ADDR_OAM) begin
			m.tgt = cbam_pkg::TGT_INT;
			lin = {16'd0, addr} - {16'd0, cbam_pkg::ECHO_OFFSET};
		end else if (addr < cbam_pkg::ADDR_UNUSABLE || addr >= cbam_pkg::ADDR_IO_START) begin
			m.tgt = cbam_pkg::TGT_INT;
			lin = {16'd0, addr};
		end
		m.phys = lin[20:0];
		m.strobe = wr && (m.tgt == cbam_pkg::TGT_INT || m.tgt == cbam_pkg::TGT_RAM);
		m.sbyte = m.strobe ? data : 8'h00;
		awaited_maps.push_back(m);
	endfunction

	function void check_result(cbam_pkg::target_t tgt, logic [20:0] phys, logic strobe,
			logic [7:0] sbyte);
		bank_map_t m;
		if (awaited_maps.size() == 0) begin
			$display("%0t: result word with no access pending: target %0d phys %h",
				$time, tgt, phys);
			failures++;
			return;
		end
		m = awaited_maps.pop_front();
		if (tgt !== m.tgt) begin
			$display("%0t: target expected %0d actual %0d", $time, m.tgt, tgt);
			failures++;
		end
		if (phys !== m.phys) begin
			$display("%0t: physical_address expected %h actual %h", $time, m.phys, phys);
			failures++;
		end
		if (strobe !== m.strobe) begin
			$display("%0t: store_strobe expected %b actual %b", $time, m.strobe, strobe);
			failures++;
		end
		if (sbyte !== m.sbyte) begin
			$display("%0t: store_byte expected %h actual %h", $time, m.sbyte, sbyte);
			failures++;
		end
	endfunction
endclass

module cartridge_bank_address_mapper_unit_tb;
	localparam int ROM_BANK_BITS = 7;
	localparam int RAM_BANKS = 4;
	localparam int RANDOM_WORDS = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic ACT_READ = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic              action = ACT_READ;
	logic [15:0]       bus_address = 16'h0000;
	logic [7:0]        write_byte = 8'h00;
	logic              result_valid;
	logic              result_stall = 1'b0;
	cbam_pkg::target_t target;
	logic [20:0]       physical_address;
	logic              store_strobe;
	logic [7:0]        store_byte;

	bank_map_ledger ledger;
	bit             tx_quiet = 1'b0;
	bit             rx_quiet = 1'b0;
	int unsigned    stall_left = 0;
	int unsigned    rx_wait;
	int unsigned    cycles = 0;

	cartridge_bank_address_mapper_unit #(
		.ROM_BANK_BITS(ROM_BANK_BITS),
		.RAM_BANKS(RAM_BANKS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.bus_address(bus_address),
		.write_byte(write_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.target(target),
		.physical_address(physical_address),
		.store_strobe(store_strobe),
		.store_byte(store_byte)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				result_stall <= 1'b0;
		end else if (arst_n && result_valid && !result_stall) begin
			if ($urandom_range(0, 15) == 0)
				rx_quiet = !rx_quiet;
			rx_wait = rx_quiet ? 0 : $urandom_range(0, 13);
			stall_left <= rx_wait;
			result_stall <= (rx_wait != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				ledger.note_access(action, bus_address, write_byte);
			if (result_valid && !result_stall)
				ledger.check_result(target, physical_address, store_strobe, store_byte);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("cartridge_bank_address_mapper_unit verification failed");
				$finish;
			end
		end
	end

	task send_access(input logic act, input logic [15:0] addr, input logic [7:0] data);
		int unsigned gap;
		if ($urandom_range(0, 15) == 0)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		bus_address <= addr;
		write_byte <= data;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (ledger.awaited() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [15:0] addr;
		logic [7:0]  data;
		logic        act;
		ledger = new(ROM_BANK_BITS, RAM_BANKS);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_access(ACT_READ, 16'h0000, 8'hFF);
		send_access(ACT_READ, 16'h7FFF, 8'h00);
		send_access(ACT_READ, 16'hA000, 8'h00);
		send_access(ACT_WRITE, 16'hBFFF, 8'h55);
		send_access(ACT_WRITE, 16'h0000, 8'h0A);
		send_access(ACT_WRITE, 16'h4000, 8'hFF);
		send_access(ACT_READ, 16'hBFFF, 8'h00);
		send_access(ACT_WRITE, 16'hA000, 8'hA5);
		send_access(ACT_WRITE, 16'h2000, 8'h00);
		send_access(ACT_READ, 16'h4000, 8'h00);
		send_access(ACT_WRITE, 16'h3FFF, 8'hFF);
		send_access(ACT_READ, 16'h7FFF, 8'h00);
		send_access(ACT_WRITE, 16'h6000, 8'h12);
		send_access(ACT_WRITE, 16'h7FFF, 8'hFF);
		send_access(ACT_READ, 16'h8000, 8'h00);
		send_access(ACT_WRITE, 16'h9FFF, 8'hFF);
		send_access(ACT_READ, 16'hC000, 8'h00);
		send_access(ACT_WRITE, 16'hDFFF, 8'h01);
		send_access(ACT_READ, 16'hE000, 8'h00);
		send_access(ACT_WRITE, 16'hFDFF, 8'h80);
		send_access(ACT_READ, 16'hFE9F, 8'h00);
		send_access(ACT_READ, 16'hFEA0, 8'h00);
		send_access(ACT_WRITE, 16'hFEFE, 8'h77);
		send_access(ACT_WRITE, 16'hFEFF, 8'h3C);
		send_access(ACT_WRITE, 16'h1FFF, 8'h0B);
		send_access(ACT_READ, 16'hFFFF, 8'h00);
		settle();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			data = 8'($urandom_range(0, 255));
			act = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 11))
				0: begin
					addr = 16'($urandom_range(16'h0000, 16'h1FFF));
					if ($urandom_range(0, 1) == 1)
						data[3:0] = cbam_pkg::RAM_ENABLE_KEY;
				end
				1: addr = 16'($urandom_range(16'h2000, 16'h3FFF));
				2: addr = 16'($urandom_range(16'h4000, 16'h5FFF));
				3: addr = 16'($urandom_range(16'h6000, 16'h7FFF));
				4: addr = 16'($urandom_range(16'h8000, 16'h9FFF));
				5, 6: addr = 16'($urandom_range(16'hA000, 16'hBFFF));
				7: addr = 16'($urandom_range(16'hC000, 16'hDFFF));
				8: addr = 16'($urandom_range(16'hE000, 16'hFDFF));
				9: addr = 16'($urandom_range(16'hFE00, 16'hFFFF));
				10: addr = 16'($urandom_range(16'hFE9E, 16'hFF00));
				default: addr = 16'($urandom_range(0, 16'hFFFF));
			endcase
			if (addr < cbam_pkg::ADDR_LATCH && $urandom_range(0, 3) != 0)
				act = ACT_WRITE;
			send_access(act, addr, data);
			if (n == RANDOM_WORDS / 2)
				settle();
		end

		settle();
		if (ledger.failures == 0)
			$display("cartridge_bank_address_mapper_unit verification clean");
		else
			$display("cartridge_bank_address_mapper_unit verification failed");
		$finish;
	end
endmodule
